### rtl/fsa_pkg.sv
// fraction sum accumulator: shared types and constants
// no dependencies

package fsa_pkg;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_ZERO = 2'd1,
    FAULT_OVF  = 2'd2
  } fault_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic               last;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SUM,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DIVW,
    ST_DONE,
    ST_EMIT
  } state_t;

endpackage

### rtl/fraction_sum_accumulator_unit.sv
// fraction sum accumulator: top level, item queue and arithmetic back end
// uses fsa_pkg, fsa_queue, fsa_core
//
// slave channel s_axis carries one signed fraction per item; tlast closes a run
// master channel m_axis carries the reduced sum once per run, on the last item
// the first fraction of a run is kept as it stands, later ones are added and
// reduced by a euclid gcd on one shared radix-2 divider
// an added item is cross-multiplied first when the denominators differ
// a first item or an item of a faulted run skips the arithmetic
// a two-entry queue takes items while the back end is busy
// fault: 0 ok, 1 zero divisor, 2 overflow; a faulted sum reads as zero
// reset clears the run, the queue and the result; a stalled receiver holds
// the result on m_axis and stops the back end, the queue then fills and
// s_axis_tready falls

module fraction_sum_accumulator_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // num_in[31:0], den_in[63:32]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // sum_num[31:0], sum_den[63:32], fault[65:64]
  output logic        m_axis_tlast
);

  fsa_pkg::item_t in_item;
  fsa_pkg::item_t q_item;
  logic           q_valid;
  logic           q_ready;
  logic [31:0]    res_num;
  logic [31:0]    res_den;
  logic [1:0]     res_fault;

  assign in_item.num  = s_axis_tdata[31:0];
  assign in_item.den  = s_axis_tdata[63:32];
  assign in_item.last = s_axis_tlast;

  fsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  fsa_core #(
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_num    (res_num),
    .res_den    (res_den),
    .res_fault  (res_fault)
  );

  assign m_axis_tdata = {6'd0, res_fault, res_den, res_num};
  assign m_axis_tlast = 1'b1;

endmodule

### rtl/fsa_queue.sv
// fraction sum accumulator: two-entry item queue between front and back
// uses fsa_pkg

module fsa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fsa_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output fsa_pkg::item_t out_item
);

  fsa_pkg::item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = mem[rd_ptr];
  assign do_wr     = in_valid && in_ready;
  assign do_rd     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

### rtl/fsa_divider.sv
// fraction sum accumulator: shared radix-2 signed divider, truncating
// no dependencies; one quotient bit per cycle, 64-bit operands

module fsa_divider (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic signed [63:0] divisor,
  output logic               busy,
  output logic signed [63:0] quotient,
  output logic signed [63:0] remainder
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        neg_q;
  logic        neg_r;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  assign rem_sh = {rem[62:0], quo[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs};
  assign quotient  = neg_q ? -$signed(quo) : $signed(quo);
  assign remainder = neg_r ? -$signed(rem) : $signed(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 7'd0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= 7'd64;
      rem   <= 64'd0;
      quo   <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      dvs   <= divisor[63] ? 64'(-divisor) : 64'(divisor);
      neg_q <= dividend[63] ^ divisor[63];
      neg_r <= dividend[63];
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

endmodule

### rtl/fsa_core.sv
// fraction sum accumulator: back end, run state, cross products, euclid gcd
// uses fsa_pkg and fsa_divider

module fsa_core #(
  parameter int WORD_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  fsa_pkg::item_t item,
  output logic           res_valid,
  input  logic           res_ready,
  output logic [31:0]    res_num,
  output logic [31:0]    res_den,
  output logic [1:0]     res_fault
);

  localparam int EB = (WORD_BITS > 32) ? 32 : ((WORD_BITS < 2) ? 2 : WORD_BITS);
  localparam logic signed [63:0] HI = 64'sd1 <<< (EB - 1);

  fsa_pkg::state_t state;
  fsa_pkg::state_t state_next;

  logic signed [63:0] acc_num;
  logic signed [63:0] acc_den;
  logic               in_run;
  logic [1:0]         fault_hold;
  logic signed [63:0] n_r;
  logic signed [63:0] d_r;
  logic               last_r;
  logic signed [63:0] p1;
  logic signed [63:0] sd;
  logic signed [63:0] sn;
  logic signed [63:0] ga;
  logic signed [63:0] gb;
  logic               gcd_wait;
  logic signed [63:0] qn;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;

  logic               div_start;
  logic signed [63:0] div_a;
  logic signed [63:0] div_b;
  logic               div_busy;
  logic signed [63:0] div_q;
  logic signed [63:0] div_r;

  logic signed [63:0] n_in;
  logic signed [63:0] d_in;

  function automatic logic oor(input logic signed [63:0] v);
    oor = (v >= HI) || (v < -HI);
  endfunction

  assign n_in = 64'(item.num);
  assign d_in = 64'(item.den);
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  fsa_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      fsa_pkg::ST_IDLE: if (item_valid) begin
        if (!in_run || fault_hold != fsa_pkg::FAULT_NONE) state_next = fsa_pkg::ST_DONE;
        else if (acc_den == d_in) state_next = fsa_pkg::ST_SUM;
        else if (acc_den == 64'sd0 || d_in == 64'sd0) state_next = fsa_pkg::ST_DONE;
        else state_next = fsa_pkg::ST_MUL1;
      end
      fsa_pkg::ST_MUL1: state_next = fsa_pkg::ST_MUL2;
      fsa_pkg::ST_MUL2: state_next = fsa_pkg::ST_MUL3;
      fsa_pkg::ST_MUL3: state_next = fsa_pkg::ST_SUM;
      fsa_pkg::ST_SUM: begin
        if (fault_hold != fsa_pkg::FAULT_NONE || oor(sn)) state_next = fsa_pkg::ST_DONE;
        else state_next = fsa_pkg::ST_GCD;
      end
      fsa_pkg::ST_GCD: if (!div_busy && !gcd_wait) begin
        if (gb == 64'sd0) state_next = (ga == 64'sd0) ? fsa_pkg::ST_DONE : fsa_pkg::ST_DIVN;
      end
      fsa_pkg::ST_DIVN: state_next = fsa_pkg::ST_DIVD;
      fsa_pkg::ST_DIVD: if (!div_busy) state_next = fsa_pkg::ST_DIVW;
      fsa_pkg::ST_DIVW: if (!div_busy) state_next = fsa_pkg::ST_DONE;
      fsa_pkg::ST_DONE: state_next = last_r ? fsa_pkg::ST_EMIT : fsa_pkg::ST_IDLE;
      fsa_pkg::ST_EMIT: if (res_ready) state_next = fsa_pkg::ST_IDLE;
      default: state_next = fsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == fsa_pkg::ST_IDLE);
    res_valid  = (state == fsa_pkg::ST_EMIT);
    res_fault  = fault_hold;
    res_num    = (fault_hold != fsa_pkg::FAULT_NONE) ? 32'd0 : acc_num[31:0];
    res_den    = (fault_hold != fsa_pkg::FAULT_NONE) ? 32'd0 : acc_den[31:0];
    div_start  = 1'b0;
    div_a      = ga;
    div_b      = gb;
    mul_a      = acc_den[31:0];
    mul_b      = d_r[31:0];
    unique case (state)
      fsa_pkg::ST_MUL2: begin mul_a = d_r[31:0]; mul_b = acc_num[31:0]; end
      fsa_pkg::ST_MUL3: begin mul_a = acc_den[31:0]; mul_b = n_r[31:0]; end
      fsa_pkg::ST_GCD:  div_start = !div_busy && !gcd_wait && (gb != 64'sd0);
      fsa_pkg::ST_DIVN: begin div_start = 1'b1; div_a = sn; div_b = ga; end
      fsa_pkg::ST_DIVD: begin div_start = !div_busy; div_a = sd; div_b = ga; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fsa_pkg::ST_IDLE;
      acc_num    <= 64'sd0;
      acc_den    <= 64'sd0;
      in_run     <= 1'b0;
      fault_hold <= fsa_pkg::FAULT_NONE;
      gcd_wait   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        fsa_pkg::ST_IDLE: if (item_valid) begin
          n_r    <= n_in;
          d_r    <= d_in;
          last_r <= item.last;
          sn     <= acc_num + n_in;
          sd     <= acc_den;
          if (!in_run) begin
            in_run <= 1'b1;
            if (oor(n_in) || oor(d_in)) begin
              acc_num    <= 64'sd0;
              acc_den    <= 64'sd0;
              fault_hold <= fsa_pkg::FAULT_OVF;
            end else begin
              acc_num    <= n_in;
              acc_den    <= d_in;
              fault_hold <= fsa_pkg::FAULT_NONE;
            end
          end else if (fault_hold == fsa_pkg::FAULT_NONE && acc_den != d_in &&
                       (acc_den == 64'sd0 || d_in == 64'sd0)) begin
            fault_hold <= fsa_pkg::FAULT_ZERO;
          end
        end
        fsa_pkg::ST_MUL1: begin
          sd <= mul_p;
          if (oor(mul_p)) fault_hold <= fsa_pkg::FAULT_OVF;
        end
        fsa_pkg::ST_MUL2: begin
          p1 <= mul_p;
          if (oor(mul_p)) fault_hold <= fsa_pkg::FAULT_OVF;
        end
        fsa_pkg::ST_MUL3: begin
          sn <= p1 + mul_p;
          if (oor(mul_p)) fault_hold <= fsa_pkg::FAULT_OVF;
        end
        fsa_pkg::ST_SUM: begin
          if (oor(sn)) fault_hold <= fsa_pkg::FAULT_OVF;
          ga <= sn;
          gb <= sd;
        end
        fsa_pkg::ST_GCD: if (!div_busy) begin
          if (gcd_wait) begin
            ga       <= gb;
            gb       <= div_r;
            gcd_wait <= 1'b0;
          end else if (gb == 64'sd0) begin
            if (ga == 64'sd0) fault_hold <= fsa_pkg::FAULT_ZERO;
          end else begin
            gcd_wait <= 1'b1;
          end
        end
        fsa_pkg::ST_DIVD: if (!div_busy) qn <= div_q;
        fsa_pkg::ST_DIVW: if (!div_busy) begin
          if (oor(qn) || oor(div_q)) begin
            fault_hold <= fsa_pkg::FAULT_OVF;
          end else begin
            acc_num <= qn;
            acc_den <= div_q;
          end
        end
        fsa_pkg::ST_DONE: if (last_r) in_run <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule
